/* rtl/sfm_pkg.sv */
// shared types, character codes and helpers for the substring first-match finder
package sfm_pkg;

  localparam int PatternMaxDefault   = 32;
  localparam int PositionBitsDefault = 16;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEXT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_CASE_FOLD      = 2'd0,
    REG_WHOLE_WORD     = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } reg_idx_t;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  localparam int CfgLenBits = 6;

  typedef struct packed {
    logic upd;
    logic clear;
    logic case_fold;
  } cell_ctl_t;

  function automatic int len_bits(input int pmax);
    int b;
    b = $clog2(pmax + 1);
    return (b > CfgLenBits) ? b : CfgLenBits;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_NEWLINE);
  endfunction

endpackage

/* rtl/sfm_cell.sv */
// one pattern position: pattern byte, partial-match bit and boundary bit
module sfm_cell
  import sfm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      wr_en,
  input  logic [7:0] wr_byte,
  input  logic [7:0] text_byte,
  input  logic      active,
  input  logic      tail,
  input  logic      d_in,
  input  logic      b_in,
  output logic      d,
  output logic      b,
  output logic      hit,
  output logic      bhit
);

  logic [7:0] pat;
  logic       eq;
  logic       d_next;
  logic       b_next;

  always_comb begin
    if (text_byte == pat) begin
      eq = 1'b1;
    end else if (ctl.case_fold) begin
      if (pat >= CHAR_UPPER_A && pat <= CHAR_UPPER_Z) begin
        eq = (text_byte == pat + CASE_OFFSET);
      end else if (pat >= CHAR_LOWER_A && pat <= CHAR_LOWER_Z) begin
        eq = (text_byte == pat - CASE_OFFSET);
      end else begin
        eq = 1'b0;
      end
    end else begin
      eq = 1'b0;
    end
  end

  assign d_next = d_in & eq & active;
  assign b_next = b_in & d_next;
  assign hit    = d_next & tail;
  assign bhit   = b_next & tail;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      d <= 1'b0;
      b <= 1'b0;
    end else if (ctl.upd) begin
      d <= d_next;
      b <= b_next;
    end
  end

endmodule

/* rtl/sfm_ctrl.sv */
// search control: decision state, byte counter, match start and result forming
module sfm_ctrl
  import sfm_pkg::*;
#(
  parameter int PATTERN_MAX   = PatternMaxDefault,
  parameter int POSITION_BITS = PositionBitsDefault,
  localparam int LenBits      = len_bits(PATTERN_MAX)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     text_acc,
  input  logic                     last,
  input  logic                     ws,
  input  logic                     case_fold,
  input  logic                     whole_word,
  input  logic [LenBits-1:0]       len_eff,
  input  logic                     full_hit,
  input  logic                     full_bhit,
  output cell_ctl_t                ctl,
  output logic                     pwb,
  output logic                     res_valid,
  output logic                     res_found,
  output logic [POSITION_BITS-1:0] res_position,
  output logic                     res_overflow
);

  localparam int CntBits   = POSITION_BITS + 1;
  localparam int StartBits = POSITION_BITS + 2;

  logic [CntBits-1:0]       cnt;
  logic [CntBits-1:0]       cnt_next;
  logic                     aw, aw_next;
  logic                     dec, dec_next;
  logic                     df, df_next;
  logic [POSITION_BITS-1:0] ms, ms_next;
  logic                     aw1, dec1, df1;
  logic                     aw2, dec2, df2;
  logic                     len_nz;
  logic                     upd;
  logic [StartBits-1:0]     start;

  assign len_nz = (len_eff != '0);
  assign start  = StartBits'(cnt) + StartBits'(1) - StartBits'(len_eff);

  always_comb begin
    aw1  = aw;
    dec1 = dec;
    df1  = df;
    ms_next = ms;
    if (!dec && !aw && !len_nz && !case_fold && cnt == '0) begin
      ms_next = '0;
      if (whole_word) begin
        aw1 = 1'b1;
      end else begin
        dec1 = 1'b1;
        df1  = 1'b1;
      end
    end
    aw2  = aw1;
    dec2 = dec1;
    df2  = df1;
    if (aw1) begin
      aw2  = 1'b0;
      dec2 = 1'b1;
      df2  = ws;
    end
    upd      = !dec2 && len_nz;
    aw_next  = aw2;
    dec_next = dec2;
    df_next  = df2;
    if (upd && full_hit && start[StartBits-1:POSITION_BITS] == '0) begin
      ms_next = start[POSITION_BITS-1:0];
      if (!whole_word) begin
        dec_next = 1'b1;
        df_next  = 1'b1;
      end else if (full_bhit) begin
        aw_next = 1'b1;
      end else begin
        dec_next = 1'b1;
        df_next  = 1'b0;
      end
    end
    cnt_next = (cnt == '1) ? cnt : cnt + CntBits'(1);
  end

  assign ctl.upd       = text_acc && upd;
  assign ctl.clear     = text_acc && last;
  assign ctl.case_fold = case_fold;

  assign res_valid    = text_acc && last;
  assign res_found    = (dec_next && df_next) || aw_next;
  assign res_position = res_found ? ms_next : '0;
  assign res_overflow = cnt_next[POSITION_BITS] && (cnt_next[POSITION_BITS-1:0] != '0);

  always_ff @(posedge clk) begin
    if (rst || (text_acc && last)) begin
      pwb <= 1'b1;
      cnt <= '0;
      aw  <= 1'b0;
      dec <= 1'b0;
      df  <= 1'b0;
      ms  <= '0;
    end else if (text_acc) begin
      pwb <= ws;
      cnt <= cnt_next;
      aw  <= aw_next;
      dec <= dec_next;
      df  <= df_next;
      ms  <= ms_next;
    end
  end

endmodule

/* rtl/sfm_obuf.sv */
// two-entry result buffer: output register plus skid register
module sfm_obuf
  import sfm_pkg::*;
#(
  parameter int WIDTH = PositionBitsDefault + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_v;
  logic [WIDTH-1:0] skid;
  logic             pop;

  assign in_ready = !skid_v;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (pop && skid_v) begin
      out_data <= skid;
      skid_v   <= 1'b0;
    end else if (push) begin
      if (out_valid && !pop) begin
        skid   <= push_data;
        skid_v <= 1'b1;
      end else begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/substring_first_match_finder_unit.sv */
// top level of the substring first-match finder
// Load beats (tuser = 0) write one pattern byte into the cell chosen by the index; text beats
// (tuser = 1) advance every cell of the shift-and chain in parallel, one byte per clock, so the
// block takes one beat every cycle while not stalled. Exactly one result beat leaves per text
// run, registered from the beat marked tlast. A two-entry output buffer lets input continue
// while a result waits; input stalls only when both entries are full. No clearing pass is needed
// after reset. Configuration writes are taken every cycle and should only be made while idle.
module substring_first_match_finder_unit
  import sfm_pkg::*;
#(
  parameter int PATTERN_MAX   = PatternMaxDefault,
  parameter int POSITION_BITS = PositionBitsDefault,
  localparam int OutBits      = ((POSITION_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // pattern_index[4:0], data_byte[12:5], zero fill
  input  logic               s_tlast,
  input  logic               s_tuser,   // command
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OutBits-1:0] m_tdata,   // position, zero fill
  output logic [1:0]         m_tuser,   // found[0], overflow[1]
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data
);

  localparam int LenBits = len_bits(PATTERN_MAX);
  localparam int ResBits = POSITION_BITS + 2;

  logic                     case_fold;
  logic                     whole_word;
  logic [CfgLenBits-1:0]    pattern_length;
  logic [LenBits-1:0]       len_eff;
  logic                     s_acc;
  logic                     text_acc;
  logic                     load_acc;
  logic [4:0]               pattern_index;
  logic [7:0]               data_byte;
  cell_ctl_t                ctl;
  logic                     pwb;
  logic [PATTERN_MAX-1:0]   d;
  logic [PATTERN_MAX-1:0]   b;
  logic [PATTERN_MAX-1:0]   hit;
  logic [PATTERN_MAX-1:0]   bhit;
  logic                     res_valid;
  logic                     res_found;
  logic [POSITION_BITS-1:0] res_position;
  logic                     res_overflow;
  logic [ResBits-1:0]       out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold      <= 1'b0;
      whole_word     <= 1'b0;
      pattern_length <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CASE_FOLD) begin
        case_fold <= cfg_data[0];
      end else if (cfg_index == REG_WHOLE_WORD) begin
        whole_word <= cfg_data[0];
      end else if (cfg_index == REG_PATTERN_LENGTH) begin
        pattern_length <= cfg_data;
      end
    end
  end

  assign len_eff = (LenBits'(pattern_length) > LenBits'(PATTERN_MAX)) ?
                   LenBits'(PATTERN_MAX) : LenBits'(pattern_length);

  assign pattern_index = s_tdata[4:0];
  assign data_byte     = s_tdata[12:5];
  assign s_acc         = s_tvalid && s_tready;
  assign text_acc      = s_acc && (s_tuser == CMD_TEXT);
  assign load_acc      = s_acc && (s_tuser == CMD_LOAD);

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic d_in;
    logic b_in;
    if (k == 0) begin : g_head
      assign d_in = 1'b1;
      assign b_in = pwb;
    end else begin : g_body
      assign d_in = d[k-1];
      assign b_in = b[k-1];
    end
    sfm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wr_en     (load_acc && (int'(pattern_index) == k)),
      .wr_byte   (data_byte),
      .text_byte (data_byte),
      .active    (LenBits'(k) < len_eff),
      .tail      (LenBits'(k + 1) == len_eff),
      .d_in      (d_in),
      .b_in      (b_in),
      .d         (d[k]),
      .b         (b[k]),
      .hit       (hit[k]),
      .bhit      (bhit[k])
    );
  end

  sfm_ctrl #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .text_acc     (text_acc),
    .last         (s_tlast),
    .ws           (is_space(data_byte)),
    .case_fold    (case_fold),
    .whole_word   (whole_word),
    .len_eff      (len_eff),
    .full_hit     (|hit),
    .full_bhit    (|bhit),
    .ctl          (ctl),
    .pwb          (pwb),
    .res_valid    (res_valid),
    .res_found    (res_found),
    .res_position (res_position),
    .res_overflow (res_overflow)
  );

  sfm_obuf #(
    .WIDTH (ResBits)
  ) u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data ({res_overflow, res_found, res_position}),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = OutBits'(out_data[POSITION_BITS-1:0]);
  assign m_tuser = out_data[ResBits-1:POSITION_BITS];

endmodule

/* tb/tb_substring_first_match_finder_unit.sv */
// self-checking testbench for the substring first-match finder: directed and random traffic
module tb_substring_first_match_finder_unit;
  import sfm_pkg::*;

  localparam int PAT_MAX        = PatternMaxDefault;
  localparam int POS_BITS       = PositionBitsDefault;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 500;
  localparam int SETTLE_CYCLES  = 4;
  localparam int REPORT_MAX     = 10;

  typedef struct {
    cmd_t       cmd;
    logic [4:0] index;
    logic [7:0] value;
    logic       last;
  } beat_t;

  typedef struct {
    logic                found;
    logic [POS_BITS-1:0] position;
    logic                overflow;
  } match_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;

  substring_first_match_finder_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [7:0]          pattern_mem [PAT_MAX];
  logic [PAT_MAX-1:0]  partial_bits = '0;
  logic [PAT_MAX-1:0]  boundary_bits = '0;
  logic                prev_space = 1'b1;
  logic                await_after = 1'b0;
  logic                decided = 1'b0;
  logic                decided_found = 1'b0;
  logic [POS_BITS:0]   byte_count = '0;
  logic [POS_BITS-1:0] start_pos = '0;
  logic                fold_mode = 1'b0;
  logic                word_mode = 1'b0;
  logic [5:0]          len_reg = '0;

  match_result_t expected_results[$];
  beat_t         pending_beats[$];

  // stimulus side view of the pattern
  logic [7:0]         pat_img [PAT_MAX];
  logic [PAT_MAX-1:0] written = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_left = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;
  int          mismatch_count = 0;
  int          idle_cycles = 0;

  function automatic logic is_blank(logic [7:0] b);
    return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_NEWLINE;
  endfunction

  function automatic logic byte_equal(logic [7:0] p, logic [7:0] t);
    if (t == p) return 1'b1;
    if (!fold_mode) return 1'b0;
    if (p >= CHAR_UPPER_A && p <= CHAR_UPPER_Z) return t == p + CASE_OFFSET;
    if (p >= CHAR_LOWER_A && p <= CHAR_LOWER_Z) return t == p - CASE_OFFSET;
    return 1'b0;
  endfunction

  function automatic void clear_search_state();
    partial_bits = '0;
    boundary_bits = '0;
    prev_space = 1'b1;
    byte_count = '0;
    await_after = 1'b0;
    decided = 1'b0;
    decided_found = 1'b0;
    start_pos = '0;
  endfunction

  function automatic void search_step(logic [7:0] b, logic last);
    int n;
    int k;
    int start;
    logic ws;
    logic [PAT_MAX-1:0] eq;
    match_result_t r;
    n = (len_reg > PAT_MAX) ? PAT_MAX : int'(len_reg);
    ws = is_blank(b);
    if (!decided && !await_after && n == 0 && !fold_mode && byte_count == 0) begin
      start_pos = '0;
      if (word_mode) await_after = 1'b1;
      else begin
        decided = 1'b1;
        decided_found = 1'b1;
      end
    end
    if (await_after) begin
      await_after = 1'b0;
      decided = 1'b1;
      decided_found = ws;
    end
    if (!decided && n > 0) begin
      eq = '0;
      for (k = 0; k < n; k++) eq[k] = byte_equal(pattern_mem[k], b);
      partial_bits = ((partial_bits << 1) | PAT_MAX'(1)) & eq;
      boundary_bits = ((boundary_bits << 1) | PAT_MAX'(prev_space)) & partial_bits;
      if (partial_bits[n-1]) begin
        start = int'(byte_count) + 1 - n;
        if (start >= 0 && start < (1 << POS_BITS)) begin
          start_pos = start[POS_BITS-1:0];
          if (!word_mode) begin
            decided = 1'b1;
            decided_found = 1'b1;
          end else if (boundary_bits[n-1]) begin
            await_after = 1'b1;
          end else begin
            decided = 1'b1;
            decided_found = 1'b0;
          end
        end
      end
    end
    prev_space = ws;
    if (byte_count != '1) byte_count++;
    if (last) begin
      r.found = (decided && decided_found) || await_after;
      r.position = r.found ? start_pos : '0;
      r.overflow = byte_count > (1 << POS_BITS);
      expected_results.push_back(r);
      clear_search_state();
    end
  endfunction

  // input driver, predicts on every accepted beat
  always @(posedge clk) begin : drive_input
    beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      clear_search_state();
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_LOAD) pattern_mem[s_tdata[4:0]] = s_tdata[12:5];
        else search_step(s_tdata[12:5], s_tlast);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= nxt.cmd;
          s_tdata <= {3'b000, nxt.value, nxt.index};
          s_tlast <= nxt.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_armed && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    match_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("result beat with nothing expected: found=%0b position=%0d overflow=%0b",
                     m_tuser[0], m_tdata, m_tuser[1]);
        end else begin
          want = expected_results.pop_front();
          if (m_tuser[0] !== want.found || m_tdata !== want.position ||
              m_tuser[1] !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("mismatch: expected found=%0b position=%0d overflow=%0b,",
                       want.found, want.position, want.overflow,
                       " got found=%0b position=%0d overflow=%0b",
                       m_tuser[0], m_tdata, m_tuser[1]);
          end
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("substring_first_match_finder_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] swap_case(logic [7:0] c);
    if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z))
      return c ^ CASE_OFFSET;
    return c;
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(2))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      default: return CHAR_NEWLINE;
    endcase
  endfunction

  function automatic logic [7:0] pattern_char();
    logic [7:0] c;
    c = CHAR_LOWER_A + 8'($urandom_range(1));
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(1) ? swap_case(c) : c;
      5: return space_char();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] text_char(int eff);
    logic [7:0] c;
    int unsigned r;
    r = $urandom_range(9);
    c = (eff > 0) ? pat_img[$urandom_range(eff - 1)] : CHAR_LOWER_A;
    if (r < 4) return c;
    if (r < 6) return swap_case(c);
    if (r < 8) return space_char();
    return 8'($urandom_range(255));
  endfunction

  function automatic void push_load(int idx, logic [7:0] val, logic last = 1'b0);
    beat_t bt;
    bt.cmd = CMD_LOAD;
    bt.index = idx[4:0];
    bt.value = val;
    bt.last = last;
    pending_beats.push_back(bt);
    pat_img[idx] = val;
    written[idx] = 1'b1;
  endfunction

  function automatic void push_text(logic [7:0] val, logic last);
    beat_t bt;
    bt.cmd = CMD_TEXT;
    bt.index = 5'($urandom_range(31));
    bt.value = val;
    bt.last = last;
    pending_beats.push_back(bt);
  endfunction

  function automatic void push_text_str(string s);
    int k;
    for (k = 0; k < s.len(); k++) push_text(s[k], k == s.len() - 1);
  endfunction

  // one text run, most of the time holding a copy of the pattern
  function automatic void text_run(int eff, int extra);
    logic [7:0] chars[$];
    int n;
    int at;
    int k;
    n = $urandom_range(eff + extra, 1);
    for (k = 0; k < n; k++) chars.push_back(text_char(eff));
    if (eff > 0 && eff <= n && $urandom_range(9) < 7) begin
      at = $urandom_range(n - eff);
      for (k = 0; k < eff; k++)
        chars[at+k] = ($urandom_range(3) == 0) ? swap_case(pat_img[k]) : pat_img[k];
      if (at > 0 && $urandom_range(1)) chars[at-1] = space_char();
      if (at + eff < n && $urandom_range(1)) chars[at+eff] = space_char();
    end
    for (k = 0; k < n; k++) begin
      if ($urandom_range(39) == 0)
        push_load($urandom_range(31), pattern_char(), 1'($urandom_range(1)));
      push_text(chars[k], k == n - 1);
    end
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [5:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CASE_FOLD:      fold_mode = val[0];
      REG_WHOLE_WORD:     word_mode = val[0];
      REG_PATTERN_LENGTH: len_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_mode(int m);
    case (m)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 9; recv_stall_pct = 9; end
    endcase
  endtask

  task automatic set_search(logic fold, logic word, logic [5:0] plen, int mode);
    write_reg(REG_CASE_FOLD, 6'(fold));
    write_reg(REG_WHOLE_WORD, 6'(word));
    write_reg(REG_PATTERN_LENGTH, plen);
    @(negedge clk);
    set_mode(mode);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0 ||
           hold_left != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(logic fold, logic word, logic [5:0] plen, int mode,
                              int beats, int extra, logic pressure);
    int eff;
    int k;
    set_search(fold, word, plen, mode);
    eff = (plen > PAT_MAX) ? PAT_MAX : int'(plen);
    for (k = 0; k < eff; k++)
      if (!written[k] || $urandom_range(2) == 0) push_load(k, pattern_char());
    if (pressure) hold_armed = 1'b1;
    while (pending_beats.size() < beats) text_run(eff, extra);
    drain();
  endtask

  initial begin
    int p;
    logic [5:0] lens [13];
    lens = '{6'd1, 6'd2, 6'd3, 6'd32, 6'd63, 6'd0, 6'd4, 6'd5, 6'd2, 6'd40, 6'd1, 6'd8, 6'd6};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // exact mode, index and byte extremes
    set_search(1'b0, 1'b0, 6'd2, 0);
    push_load(31, 8'hff, 1'b1);
    push_load(0, CHAR_LOWER_A);
    push_load(1, CHAR_UPPER_Z);
    push_text(8'h00, 1'b0);
    push_text_str("aZ");
    push_text(8'hff, 1'b1);
    push_text_str("a");
    drain();
    // empty pattern cases
    set_search(1'b0, 1'b0, 6'd0, 0);
    push_text_str("q");
    drain();
    set_search(1'b0, 1'b1, 6'd0, 0);
    push_text_str(" x");
    push_text_str("x");
    drain();
    set_search(1'b1, 1'b0, 6'd0, 0);
    push_text_str("b");
    drain();
    // folding with whole word
    set_search(1'b1, 1'b1, 6'd2, 0);
    push_text_str("x Az y");
    push_text_str("xaz az");
    push_text_str("\taZ");
    drain();

    for (p = 0; p < 13; p++)
      random_phase(p[0], p[1] ^ p[2], lens[p], (p + p / 4) % 4, 58, 12, 1'b0);
    random_phase(1'b0, 1'b0, 6'd1, 0, 70, 1, 1'b1);

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("substring_first_match_finder_unit regression: pass");
    else
      $display("substring_first_match_finder_unit regression: fail");
    $finish;
  end

endmodule
